### sv/rtfcw_pkg.sv
`default_nettype none

package rtfcw_pkg;

    // Number of control-word characters kept for matching.
    localparam int WORD_CHARS = 3;
    // Width of the brace depth counter; it saturates at all ones and at zero.
    localparam int DEPTH_WIDTH = 8;

    localparam int LEN_W = 3;
    localparam logic [LEN_W-1:0] LEN_SAT = {LEN_W{1'b1}};
    localparam int WIDX_W = (WORD_CHARS > 1) ? $clog2(WORD_CHARS) : 1;

    localparam int DATA_W = 8;
    localparam int ADDR_W = 3;

    localparam logic [ADDR_W-1:0] ADDR_RTF_MODE = 3'd0;

    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_B       = 8'h62;
    localparam logic [7:0] CH_I       = 8'h69;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_P       = 8'h70;
    localparam logic [7:0] CH_A       = 8'h61;
    localparam logic [7:0] CH_R       = 8'h72;

    localparam logic KIND_TEXT  = 1'b0;
    localparam logic KIND_BREAK = 1'b1;

endpackage

`default_nettype wire

### sv/rtf_control_word_parser_unit.sv
`default_nettype none

// Channel   Role    Handshake         Payload
// s_        in      tvalid/tready     tdata: data_byte; tuser: first_of_file
// m_        out     tvalid/tready     tdata: char_code, is_bold, is_italic; tuser: item_kind
// apb       config  psel/penable      register 0 rtf_mode at byte address 0
//
// One byte is taken per cycle. The parser state and the decision for a byte are
// settled in the cycle the byte is accepted; the result sits in the output
// register from the next cycle. The output register is the only stall point: a new
// byte is taken whenever that register is empty or is being drained. Reset
// clears the parser state and sets rtf_mode; the word character store is not
// cleared.

module rtf_control_word_parser_unit
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // [7:0] data_byte
    input  wire logic                          s_tuser,   // [0] first_of_file

    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [15:0]                        m_tdata,   // [7:0] char_code, [8] is_bold,
                                                          // [9] is_italic, rest zero
    output logic                               m_tuser,   // [0] item_kind

    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rtfcw_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [rtfcw_pkg::DATA_W*4-1:0] pwdata,
    output logic [rtfcw_pkg::DATA_W*4-1:0]     prdata,
    output logic                               pready
);

    localparam logic [rtfcw_pkg::DEPTH_WIDTH-1:0] DEPTH_MAX = {rtfcw_pkg::DEPTH_WIDTH{1'b1}};
    localparam logic [rtfcw_pkg::DEPTH_WIDTH-1:0] DEPTH_ONE =
        {{(rtfcw_pkg::DEPTH_WIDTH-1){1'b0}}, 1'b1};

    logic                                 rtf_mode_reg;
    logic                                 in_word_reg,  in_word_next;
    logic                                 after_bs_reg, after_bs_next;
    logic [rtfcw_pkg::LEN_W-1:0]          len_reg,      len_next;
    logic                                 bold_reg,     bold_next;
    logic                                 italic_reg,   italic_next;
    logic [rtfcw_pkg::DEPTH_WIDTH-1:0]    depth_reg,    depth_next;
    logic [7:0]                           word_reg [rtfcw_pkg::WORD_CHARS];

    logic                                 out_valid_reg, out_valid_next;
    logic                                 out_kind_reg;
    logic [7:0]                           out_code_reg;
    logic                                 out_bold_reg;
    logic                                 out_italic_reg;

    logic                                 accept;
    logic [7:0]                           c;
    logic                                 cur_in_word, cur_after_bs, cur_bold, cur_italic;
    logic [rtfcw_pkg::LEN_W-1:0]          cur_len;
    logic [rtfcw_pkg::DEPTH_WIDTH-1:0]    cur_depth;
    logic                                 delim;
    logic                                 char_store;
    logic                                 emit;
    logic                                 emit_kind;
    logic [7:0]                           emit_code;
    logic                                 brace_step;
    logic                                 cfg_write;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign c        = s_tdata;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {6'd0, out_italic_reg, out_bold_reg, out_code_reg};

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == rtfcw_pkg::ADDR_RTF_MODE);
    assign prdata    = (paddr == rtfcw_pkg::ADDR_RTF_MODE) ?
                       {{(rtfcw_pkg::DATA_W*4-1){1'b0}}, rtf_mode_reg} : '0;

    // Start of file wipes the parser state before the byte is looked at.
    assign cur_in_word  = s_tuser ? 1'b0 : in_word_reg;
    assign cur_after_bs = s_tuser ? 1'b0 : after_bs_reg;
    assign cur_len      = s_tuser ? '0   : len_reg;
    assign cur_bold     = s_tuser ? 1'b0 : bold_reg;
    assign cur_italic   = s_tuser ? 1'b0 : italic_reg;
    assign cur_depth    = s_tuser ? '0   : depth_reg;

    assign delim = c inside {rtfcw_pkg::CH_BSLASH, rtfcw_pkg::CH_LBRACE, rtfcw_pkg::CH_RBRACE,
                             rtfcw_pkg::CH_SPACE, rtfcw_pkg::CH_NEWLINE};

    always_comb
    begin
        in_word_next  = cur_in_word;
        after_bs_next = cur_after_bs;
        len_next      = cur_len;
        bold_next     = cur_bold;
        italic_next   = cur_italic;
        brace_step    = 1'b0;
        char_store    = 1'b0;
        emit          = 1'b0;
        emit_kind     = rtfcw_pkg::KIND_TEXT;
        emit_code     = c;

        if (cur_in_word)
        begin
            if (!delim)
            begin
                char_store    = ({{(32-rtfcw_pkg::LEN_W){1'b0}}, cur_len} <
                                 rtfcw_pkg::WORD_CHARS);
                if (cur_len != rtfcw_pkg::LEN_SAT)
                    len_next = cur_len + 1'b1;
                after_bs_next = 1'b0;
            end
            else if (cur_after_bs)
            begin
                // Escaped delimiter: it is ordinary text.
                in_word_next  = 1'b0;
                after_bs_next = 1'b0;
                len_next      = '0;
                emit          = (cur_depth == DEPTH_ONE);
            end
            else
            begin
                if (cur_len == 3'd1 && word_reg[0] == rtfcw_pkg::CH_B)
                    bold_next = 1'b1;
                else if (cur_len == 3'd2 && word_reg[0] == rtfcw_pkg::CH_B &&
                         word_reg[1] == rtfcw_pkg::CH_ZERO)
                    bold_next = 1'b0;
                else if (cur_len == 3'd1 && word_reg[0] == rtfcw_pkg::CH_I)
                    italic_next = 1'b1;
                else if (cur_len == 3'd2 && word_reg[0] == rtfcw_pkg::CH_I &&
                         word_reg[1] == rtfcw_pkg::CH_ZERO)
                    italic_next = 1'b0;
                else if (cur_len == 3'd3 && word_reg[0] == rtfcw_pkg::CH_P &&
                         word_reg[1] == rtfcw_pkg::CH_A && word_reg[2] == rtfcw_pkg::CH_R)
                begin
                    emit      = 1'b1;
                    emit_kind = rtfcw_pkg::KIND_BREAK;
                    emit_code = rtfcw_pkg::CH_NEWLINE;
                end
                len_next = '0;
                if (c == rtfcw_pkg::CH_BSLASH)
                begin
                    after_bs_next = 1'b1;
                end
                else
                begin
                    in_word_next  = 1'b0;
                    after_bs_next = 1'b0;
                    brace_step    = (c == rtfcw_pkg::CH_LBRACE) || (c == rtfcw_pkg::CH_RBRACE);
                end
            end
        end
        else if (rtf_mode_reg)
        begin
            if (c == rtfcw_pkg::CH_BSLASH)
            begin
                in_word_next  = 1'b1;
                after_bs_next = 1'b1;
                len_next      = '0;
            end
            else if (c == rtfcw_pkg::CH_LBRACE || c == rtfcw_pkg::CH_RBRACE)
            begin
                brace_step = 1'b1;
            end
            else if (c != rtfcw_pkg::CH_NEWLINE)
            begin
                emit = (cur_depth == DEPTH_ONE);
            end
        end
        else
        begin
            emit      = 1'b1;
            emit_kind = (c == rtfcw_pkg::CH_NEWLINE) ? rtfcw_pkg::KIND_BREAK
                                                     : rtfcw_pkg::KIND_TEXT;
        end

        depth_next = cur_depth;
        if (brace_step)
        begin
            if (c == rtfcw_pkg::CH_LBRACE)
            begin
                if (cur_depth != DEPTH_MAX)
                    depth_next = cur_depth + 1'b1;
            end
            else if (cur_depth != '0)
            begin
                depth_next = cur_depth - 1'b1;
            end
        end

        if (accept)
            out_valid_next = emit;
        else
            out_valid_next = out_valid_reg && !m_tready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rtf_mode_reg  <= 1'b1;
            in_word_reg   <= 1'b0;
            after_bs_reg  <= 1'b0;
            len_reg       <= '0;
            bold_reg      <= 1'b0;
            italic_reg    <= 1'b0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                rtf_mode_reg <= pwdata[0];
            if (accept)
            begin
                in_word_reg  <= in_word_next;
                after_bs_reg <= after_bs_next;
                len_reg      <= len_next;
                bold_reg     <= bold_next;
                italic_reg   <= italic_next;
                depth_reg    <= depth_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Only entries below the current word length are ever compared.
    always_ff @(posedge clk)
    begin
        if (accept && char_store)
            word_reg[cur_len[rtfcw_pkg::WIDX_W-1:0]] <= c;
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_kind_reg   <= emit_kind;
            out_code_reg   <= emit_code;
            out_bold_reg   <= cur_bold;
            out_italic_reg <= cur_italic;
        end
    end

endmodule

`default_nettype wire

### sv/rtfcw_checker.sv
`default_nettype none

module rtfcw_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tuser
);

    // A waiting result must not vanish.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // The input side only stalls when the output register is full and blocked.
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !(m_tvalid && !m_tready) |-> s_tready)
        else $error("input stalled with free output register");

    // Every paragraph break carries a newline code and no stray upper bits.
    a_break_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[7:0] == 8'h0A && m_tdata[15:10] == 6'd0)
        else $error("paragraph break with wrong code");

    // Without an accepted byte no new result can show up.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tvalid && s_tready) && !m_tvalid |=> !m_tvalid)
        else $error("result without an input byte");

endmodule

bind rtf_control_word_parser_unit rtfcw_checker u_rtfcw_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
